@@ sv/atssd_pkg.sv @@
// ----------------------------------------------------------------------------
// atssd_pkg
// Shared types and constants for the accelerometer tap/step/shake detector.
// ----------------------------------------------------------------------------
package atssd_pkg;

  // Default number of warm-up samples after reset or a register write
  localparam int HISTORY_LEN_DEF = 8;

  // Q0.16 filter coefficients
  localparam logic [15:0] C_MEAN_OLD = 16'd58982;  // 0.9
  localparam logic [15:0] C_MEAN_CUR = 16'd3932;   // 0.06
  localparam logic [15:0] C_MEAN_PRV = 16'd2621;   // 0.04
  localparam logic [15:0] C_DEV_OLD  = 16'd39322;  // 0.6
  localparam logic [15:0] C_DEV_ERR  = 16'd58982;  // 0.9

  localparam logic [17:0] DEV_MAX = 18'h3FFFF;

  // Widths of the multiply-accumulate unit
  localparam int MAC_A_W   = 16;
  localparam int MAC_B_W   = 18;
  localparam int MAC_ACC_W = 36;

  // Configuration register indexes
  localparam logic [2:0] CFG_TAP_THR   = 3'd0;
  localparam logic [2:0] CFG_STEP_THR  = 3'd1;
  localparam logic [2:0] CFG_SHAKE_THR = 3'd2;
  localparam logic [2:0] CFG_TAP_TO    = 3'd3;
  localparam logic [2:0] CFG_STEP_TO   = 3'd4;
  localparam logic [2:0] CFG_SHAKE_TO  = 3'd5;

  // Register reset values
  localparam logic [17:0] RST_TAP_THR   = 18'd128;
  localparam logic [17:0] RST_STEP_THR  = 18'd256;
  localparam logic [17:0] RST_SHAKE_THR = 18'd1024;
  localparam logic [15:0] RST_TAP_TO    = 16'd300;
  localparam logic [15:0] RST_STEP_TO   = 16'd1000;
  localparam logic [15:0] RST_SHAKE_TO  = 16'd1000;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic tap_seen;
    logic double_tap_seen;
    logic step_seen;
    logic shake_seen;
  } out_word_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;   // accumulate this cycle
    logic clr;  // start a new sum instead of adding to the old one
    logic rnd;  // seed a new sum with one half in Q0.16, for rounding
  } mac_ctl_t;

endpackage

@@ sv/atssd_mac.sv @@
// ----------------------------------------------------------------------------
// atssd_mac
// Shared unsigned multiply-accumulate unit, one product per cycle while enabled.
// ----------------------------------------------------------------------------
module atssd_mac
  import atssd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  mac_ctl_t               ctl,
  input  logic [MAC_A_W-1:0]     op_a,
  input  logic [MAC_B_W-1:0]     op_b,
  output logic [MAC_ACC_W-1:0]   acc
);

  localparam logic [MAC_ACC_W-1:0] RND_HALF = MAC_ACC_W'(32768);

  logic [MAC_A_W+MAC_B_W-1:0] prod;
  logic [MAC_ACC_W-1:0]       base;
  logic [MAC_ACC_W-1:0]       acc_r;
  logic [MAC_ACC_W-1:0]       acc_nxt;

  assign prod = op_a * op_b;

  always_comb begin
    if (ctl.clr) begin
      base = ctl.rnd ? RND_HALF : '0;
    end else begin
      base = acc_r;
    end
    acc_nxt = base + MAC_ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ sv/atssd_sqrt.sv @@
// ----------------------------------------------------------------------------
// atssd_sqrt
// Iterative floor square root of a 32-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module atssd_sqrt
  import atssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] rem_r,  rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [31:0] bit_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] trial;

  // One restoring step: try to take root+bit out of the remainder
  always_comb begin
    trial = root_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt  = rem_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      rem_nxt  = rem_r;
      root_nxt = root_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= radicand;
        root_r <= '0;
        bit_r  <= 32'h4000_0000;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        cnt_r  <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r[15:0];

endmodule

@@ sv/accel_tap_step_shake_detector.sv @@
// ----------------------------------------------------------------------------
// accel_tap_step_shake_detector
// Sequence: an accepted word passes through three squarings, the 16-step
//   square root and, for a warmed-up sample, the five filter products on the
//   shared multiply-accumulate unit before its result word reaches the
//   output register; during warm-up the filter products are skipped.
// Flow: one word at a time; in_stall stays high until the result is in the
//   output register, so a stalled result holds the block.
// Reset (rst_n low, synchronous): registers back to defaults, filters and
//   event times cleared, warm-up restarted, output register empty.
// ----------------------------------------------------------------------------
module accel_tap_step_shake_detector
  import atssd_pkg::*;
#(
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  // configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);

  // Warm-up counter just wide enough to hold HISTORY_LEN
  localparam int WCW = $clog2(HISTORY_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a word
    S_SQ,     // square and sum the three axes
    S_SQW,    // sum ready, launch the root
    S_ROOT,   // wait for the root
    S_MEAN,   // mean filter taps
    S_MEANW,  // take the new mean and the error
    S_DEV,    // deviation filter taps
    S_DEVW,   // saturate the deviation
    S_EVT,    // threshold and timeout checks
    S_FIN     // hand the result to the output register
  } state_t;

  state_t state_r;
  logic [1:0] cnt_r;

  // configuration registers
  logic [17:0] tap_thr_r, step_thr_r, shake_thr_r;
  logic [15:0] tap_to_r, step_to_r, shake_to_r;

  // detector state
  logic [WCW-1:0] warm_cnt_r;
  logic           warmed_r;
  logic [15:0]    prev_r, mean_r, mag_r, diff_r;
  logic [17:0]    dev_r;
  logic [31:0]    last_tap_r, last_step_r, last_shake_r;

  in_word_t  in_r;
  out_word_t flags_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  // shared unit hookup
  mac_ctl_t               mac_ctl;
  logic [MAC_A_W-1:0]     mac_a;
  logic [MAC_B_W-1:0]     mac_b;
  logic [MAC_ACC_W-1:0]   mac_acc;
  logic [15:0]            axis_abs;

  logic        sq_start;
  logic        sq_done;
  logic [15:0] sq_root;

  // derived values
  logic [15:0]   mean_new;
  logic [17:0]   dev_new;
  logic [31:0]   dt_tap, dt_step, dt_shake;
  logic [WCW:0]  warm_inc;
  logic          out_free;
  out_word_t     evt_flags;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = 16'(-v);
    return v[15] ? neg : 16'(v);
  endfunction

  // Pick the axis to square
  always_comb begin
    case (cnt_r)
      2'd0:    axis_abs = abs16(in_r.accel_x);
      2'd1:    axis_abs = abs16(in_r.accel_y);
      default: axis_abs = abs16(in_r.accel_z);
    endcase
  end

  // Operand and control select for the shared multiply-accumulate unit
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_r)
      S_SQ: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (cnt_r == 2'd0);
        mac_a       = axis_abs;
        mac_b       = MAC_B_W'(axis_abs);
      end
      S_MEAN: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (cnt_r == 2'd0);
        mac_ctl.rnd = 1'b1;
        case (cnt_r)
          2'd0: begin
            mac_a = C_MEAN_OLD;
            mac_b = MAC_B_W'(mean_r);
          end
          2'd1: begin
            mac_a = C_MEAN_CUR;
            mac_b = MAC_B_W'(mag_r);
          end
          default: begin
            mac_a = C_MEAN_PRV;
            mac_b = MAC_B_W'(prev_r);
          end
        endcase
      end
      S_DEV: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (cnt_r == 2'd0);
        mac_ctl.rnd = 1'b1;
        if (cnt_r == 2'd0) begin
          mac_a = C_DEV_OLD;
          mac_b = dev_r;
        end else begin
          mac_a = C_DEV_ERR;
          mac_b = MAC_B_W'(diff_r);
        end
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  atssd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  assign sq_start = (state_r == S_SQW);

  atssd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mac_acc[31:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Mean never exceeds 16 bits after the shift; deviation may need clamping
  assign mean_new = mac_acc[31:16];
  assign dev_new  = (mac_acc[35:16] > 20'(DEV_MAX)) ? DEV_MAX : mac_acc[33:16];

  // Elapsed times wrap modulo 2^32
  assign dt_tap   = in_r.time_ms - last_tap_r;
  assign dt_step  = in_r.time_ms - last_step_r;
  assign dt_shake = in_r.time_ms - last_shake_r;

  assign warm_inc = (WCW+1)'(warm_cnt_r) + (WCW+1)'(1);
  assign out_free = !out_valid_r || !out_stall;

  // Event flags for a warmed-up sample
  always_comb begin
    evt_flags = '0;
    if (dev_r > tap_thr_r) begin
      evt_flags.tap_seen        = 1'b1;
      evt_flags.double_tap_seen = (dt_tap < 32'(tap_to_r));
    end
    // Step and shake are only evaluated once their timeout has passed
    if (dt_step > 32'(step_to_r)) begin
      evt_flags.step_seen = (dev_r > step_thr_r);
    end
    if (dt_shake > 32'(shake_to_r)) begin
      evt_flags.shake_seen = (dev_r > shake_thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      tap_thr_r    <= RST_TAP_THR;
      step_thr_r   <= RST_STEP_THR;
      shake_thr_r  <= RST_SHAKE_THR;
      tap_to_r     <= RST_TAP_TO;
      step_to_r    <= RST_STEP_TO;
      shake_to_r   <= RST_SHAKE_TO;
      warm_cnt_r   <= '0;
      warmed_r     <= 1'b0;
      prev_r       <= '0;
      mean_r       <= '0;
      dev_r        <= '0;
      last_tap_r   <= '0;
      last_step_r  <= '0;
      last_shake_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // Load a new result word, or drop the old one once the sink takes it
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_word;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            state_r <= S_SQW;
          end
        end
        S_SQW: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            cnt_r <= '0;
            if (!warmed_r) begin
              // Warm-up: only remember the magnitude, report nothing
              prev_r  <= sq_root;
              flags_r <= '0;
              if (warm_inc >= (WCW+1)'(HISTORY_LEN)) begin
                warm_cnt_r <= '0;
                warmed_r   <= 1'b1;
              end else begin
                warm_cnt_r <= warm_inc[WCW-1:0];
              end
              state_r <= S_FIN;
            end else begin
              mag_r   <= sq_root;
              state_r <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            state_r <= S_MEANW;
          end
        end
        S_MEANW: begin
          mean_r  <= mean_new;
          diff_r  <= (mag_r >= mean_new) ? (mag_r - mean_new) : (mean_new - mag_r);
          cnt_r   <= '0;
          state_r <= S_DEV;
        end
        S_DEV: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            state_r <= S_DEVW;
          end
        end
        S_DEVW: begin
          dev_r   <= dev_new;
          prev_r  <= mag_r;
          state_r <= S_EVT;
        end
        S_EVT: begin
          flags_r <= evt_flags;
          if (dev_r > tap_thr_r) begin
            last_tap_r <= in_r.time_ms;
          end
          if (dt_step > 32'(step_to_r)) begin
            last_step_r <= in_r.time_ms;
          end
          if (dt_shake > 32'(shake_to_r)) begin
            last_shake_r <= in_r.time_ms;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          // Hold here until the output register can take the word
          if (out_free) begin
            out_word_r <= flags_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Register writes restart warm-up; filters and event times stay
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAP_THR: begin
            tap_thr_r  <= cfg_wdata;
            warm_cnt_r <= '0;
            warmed_r   <= 1'b0;
          end
          CFG_STEP_THR: begin
            step_thr_r <= cfg_wdata;
            warm_cnt_r <= '0;
            warmed_r   <= 1'b0;
          end
          CFG_SHAKE_THR: begin
            shake_thr_r <= cfg_wdata;
            warm_cnt_r  <= '0;
            warmed_r    <= 1'b0;
          end
          CFG_TAP_TO: begin
            tap_to_r   <= cfg_wdata[15:0];
            warm_cnt_r <= '0;
            warmed_r   <= 1'b0;
          end
          CFG_STEP_TO: begin
            step_to_r  <= cfg_wdata[15:0];
            warm_cnt_r <= '0;
            warmed_r   <= 1'b0;
          end
          CFG_SHAKE_TO: begin
            shake_to_r <= cfg_wdata[15:0];
            warm_cnt_r <= '0;
            warmed_r   <= 1'b0;
          end
          default: begin
            // unmapped index: ignore
          end
        endcase
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The root unit only finishes while the sequencer waits for it
  a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_ROOT)
    else $error("root finished outside its wait state");

  // A new result word only comes from the hand-off state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result word loaded outside hand-off");

  // A double tap is always also a tap
  a_double_is_tap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.tap_seen || !out_word_r.double_tap_seen))
    else $error("double tap without tap");

  // Warm-up count wraps before it reaches the history length
  a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (WCW+1)'(warm_cnt_r) < (WCW+1)'(HISTORY_LEN))
    else $error("warm-up count out of range");

endmodule
